// ----- rtl/cvxh_pkg.sv -----
package cvxh_pkg;

   localparam int MaxPointsDefault = 32;
   localparam int CoordBitsDefault = 24;

   // Sequencer states: load, insertion sort, duplicate removal, the two
   // chain passes with their turn check, and vertex output.
   typedef enum logic [4:0] {
      S_LOAD,
      S_SORT_NEXT,
      S_SORT_KEY,
      S_SORT_RD,
      S_SORT_CMP,
      S_DD_INIT,
      S_DD_FIRST,
      S_DD_NEXT,
      S_DD_CMP,
      S_HULL_INIT,
      S_SINGLE,
      S_PUSH,
      S_PUSH_WR,
      S_CHECK,
      S_CHK_A1,
      S_CHK_A2,
      S_CHK_CMP,
      S_ADV,
      S_FINISH,
      S_EMIT_RD,
      S_EMIT_PT,
      S_EMIT_LD,
      S_EMIT_WAIT
   } cvxh_state_type;

endpackage

// ----- rtl/cvxh_if.sv -----
interface cvxh_req_if #(
   parameter int COORD_BITS = cvxh_pkg::CoordBitsDefault
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cvxh_rsp_if #(
   parameter int COORD_BITS = cvxh_pkg::CoordBitsDefault
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] hull_x;
   logic signed [COORD_BITS-1:0] hull_y;
   logic                         last_vertex;
   logic                         overflow;

   modport source (output valid, hull_x, hull_y, last_vertex, overflow, input ready);
   modport sink (input valid, hull_x, hull_y, last_vertex, overflow, output ready);
endinterface

// ----- rtl/convex_hull_monotone_chain.sv -----
// Operation: points are taken while loading; the point that closes a set starts an
// insertion sort, duplicate removal and two chain passes of pushes, turn checks and pops,
// all sequenced over the single point memory port, then the vertex output, which the
// output stall can hold.
// Throughput: one set at a time; no point is taken while a set is computed or emitted.
// Reset: synchronous, active high; clears the sequencer, point count, overflow flag and stack top, not the memories.
module convex_hull_monotone_chain #(
   parameter int MAX_POINTS = cvxh_pkg::MaxPointsDefault,
   parameter int COORD_BITS = cvxh_pkg::CoordBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   cvxh_req_if.sink   req,
   cvxh_rsp_if.source rsp
);

   // Index widths: IW addresses the point store, CW counts points up to MAX_POINTS,
   // SW addresses the hull stack and TW counts stack entries up to its depth.
   localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int SD = 2 * MAX_POINTS + 2;
   localparam int SW = $clog2(SD);
   localparam int TW = $clog2(SD + 1);
   localparam int PTW = 2 * COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   // The point store holds {x, y}; the hull stack holds store indices. Both are
   // synchronous memories with one write and one registered read per cycle.
   logic [PTW-1:0] pstore [MAX_POINTS];
   logic [IW-1:0]  hstack [SD];

   logic           ps_we;
   logic [IW-1:0]  ps_waddr;
   logic [PTW-1:0] ps_wdata;
   logic [IW-1:0]  ps_raddr;
   logic [PTW-1:0] ps_rdata_ff;
   logic           st_we;
   logic [SW-1:0]  st_waddr;
   logic [IW-1:0]  st_wdata;
   logic [SW-1:0]  st_raddr;
   logic [IW-1:0]  st_rdata_ff;

   cvxh_pkg::cvxh_state_type state_ff, state_in;

   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           ovf_ff, ovf_in;
   logic [CW-1:0]  i_ff, i_in;
   logic [CW-1:0]  j_ff, j_in;
   logic [CW-1:0]  m_ff, m_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [PTW-1:0] t_ff, t_in;
   logic [PTW-1:0] prev_ff, prev_in;
   logic [TW-1:0]  top_ff, top_in;
   logic [TW-1:0]  floor_ff, floor_in;
   logic           upper_ff, upper_in;
   logic [IW-1:0]  p1_idx_ff, p1_idx_in;
   logic [PTW-1:0] p1_pt_ff, p1_pt_in;
   logic [IW-1:0]  p2_idx_ff, p2_idx_in;
   logic [PTW-1:0] p2_pt_ff, p2_pt_in;
   logic [IW-1:0]  a_idx_ff, a_idx_in;
   logic [PTW-1:0] a_pt_ff, a_pt_in;
   logic signed [PW-1:0] prod_l_ff, prod_l_in;
   logic signed [PW-1:0] prod_r_ff, prod_r_in;
   logic [TW-1:0]  ecnt_ff, ecnt_in;
   logic [TW-1:0]  e_ff, e_in;
   logic [PTW-1:0] out_pt_ff, out_pt_in;
   logic           out_last_ff, out_last_in;

   // Strict ordering by x, then y, both signed.
   function automatic logic pt_greater(input logic [PTW-1:0] p, input logic [PTW-1:0] q);
      logic signed [COORD_BITS-1:0] px, py, qx, qy;
      px = $signed(p[PTW-1:COORD_BITS]);
      py = $signed(p[COORD_BITS-1:0]);
      qx = $signed(q[PTW-1:COORD_BITS]);
      qy = $signed(q[COORD_BITS-1:0]);
      return (px > qx) || ((px == qx) && (py > qy));
   endfunction

   logic req_fire, rsp_fire;
   logic store_full;
   logic sort_done, j_zero, shift_up;
   logic dd_done, dd_keep;
   logic chk_go, clockwise;
   logic lower_end, upper_end;
   logic [TW-1:0] hull_len;

   logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;

   assign req_fire   = req.valid && req.ready;
   assign rsp_fire   = rsp.valid && rsp.ready;
   assign store_full = (cnt_ff == CW'(MAX_POINTS));
   assign sort_done  = (i_ff >= cnt_ff);
   assign j_zero     = (j_ff == '0);
   assign shift_up   = pt_greater(ps_rdata_ff, t_ff);
   assign dd_done    = (i_ff >= cnt_ff);
   assign dd_keep    = pt_greater(ps_rdata_ff, prev_ff);
   assign chk_go     = (top_ff >= floor_ff) && (top_ff >= TW'(3));
   assign clockwise  = (prod_l_ff < prod_r_ff);
   assign lower_end  = (k_ff == CW'(m_ff - CW'(1)));
   assign upper_end  = (k_ff == '0);
   assign hull_len   = (top_ff == '0) ? '0 :
                       ((TW'(top_ff - TW'(1)) > TW'(MAX_POINTS)) ? TW'(MAX_POINTS)
                                                               : TW'(top_ff - TW'(1)));

   // Turn at b on the path a -> b -> c, where c is the stack top, b the entry
   // below it and a the entry read back from the stack memory.
   assign ax = $signed(ps_rdata_ff[PTW-1:COORD_BITS]);
   assign ay = $signed(ps_rdata_ff[COORD_BITS-1:0]);
   assign bx = $signed(p2_pt_ff[PTW-1:COORD_BITS]);
   assign by = $signed(p2_pt_ff[COORD_BITS-1:0]);
   assign cx = $signed(p1_pt_ff[PTW-1:COORD_BITS]);
   assign cy = $signed(p1_pt_ff[COORD_BITS-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cvxh_pkg::S_LOAD: begin
            if (req_fire && req.last_point) state_in = cvxh_pkg::S_SORT_NEXT;
         end
         cvxh_pkg::S_SORT_NEXT: state_in = sort_done ? cvxh_pkg::S_DD_INIT
                                                     : cvxh_pkg::S_SORT_KEY;
         cvxh_pkg::S_SORT_KEY:  state_in = cvxh_pkg::S_SORT_RD;
         cvxh_pkg::S_SORT_RD:   state_in = j_zero ? cvxh_pkg::S_SORT_NEXT
                                                  : cvxh_pkg::S_SORT_CMP;
         cvxh_pkg::S_SORT_CMP:  state_in = shift_up ? cvxh_pkg::S_SORT_RD
                                                    : cvxh_pkg::S_SORT_NEXT;
         cvxh_pkg::S_DD_INIT:   state_in = cvxh_pkg::S_DD_FIRST;
         cvxh_pkg::S_DD_FIRST:  state_in = cvxh_pkg::S_DD_NEXT;
         cvxh_pkg::S_DD_NEXT:   state_in = dd_done ? cvxh_pkg::S_HULL_INIT
                                                   : cvxh_pkg::S_DD_CMP;
         cvxh_pkg::S_DD_CMP:    state_in = cvxh_pkg::S_DD_NEXT;
         cvxh_pkg::S_HULL_INIT: state_in = (m_ff == CW'(1)) ? cvxh_pkg::S_SINGLE
                                                            : cvxh_pkg::S_PUSH;
         cvxh_pkg::S_SINGLE:    state_in = cvxh_pkg::S_EMIT_RD;
         cvxh_pkg::S_PUSH:      state_in = cvxh_pkg::S_PUSH_WR;
         cvxh_pkg::S_PUSH_WR:   state_in = cvxh_pkg::S_CHECK;
         cvxh_pkg::S_CHECK:     state_in = chk_go ? cvxh_pkg::S_CHK_A1 : cvxh_pkg::S_ADV;
         cvxh_pkg::S_CHK_A1:    state_in = cvxh_pkg::S_CHK_A2;
         cvxh_pkg::S_CHK_A2:    state_in = cvxh_pkg::S_CHK_CMP;
         cvxh_pkg::S_CHK_CMP:   state_in = clockwise ? cvxh_pkg::S_ADV : cvxh_pkg::S_CHECK;
         cvxh_pkg::S_ADV:       state_in = (upper_ff && upper_end) ? cvxh_pkg::S_FINISH
                                                                   : cvxh_pkg::S_PUSH;
         cvxh_pkg::S_FINISH:    state_in = cvxh_pkg::S_EMIT_RD;
         cvxh_pkg::S_EMIT_RD:   state_in = cvxh_pkg::S_EMIT_PT;
         cvxh_pkg::S_EMIT_PT:   state_in = cvxh_pkg::S_EMIT_LD;
         cvxh_pkg::S_EMIT_LD:   state_in = cvxh_pkg::S_EMIT_WAIT;
         cvxh_pkg::S_EMIT_WAIT: begin
            if (rsp_fire) state_in = out_last_ff ? cvxh_pkg::S_LOAD : cvxh_pkg::S_EMIT_RD;
         end
         default:               state_in = cvxh_pkg::S_LOAD;
      endcase
   end

   // Datapath, memory controls and handshake outputs.
   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      m_in        = m_ff;
      k_in        = k_ff;
      t_in        = t_ff;
      prev_in     = prev_ff;
      top_in      = top_ff;
      floor_in    = floor_ff;
      upper_in    = upper_ff;
      p1_idx_in   = p1_idx_ff;
      p1_pt_in    = p1_pt_ff;
      p2_idx_in   = p2_idx_ff;
      p2_pt_in    = p2_pt_ff;
      a_idx_in    = a_idx_ff;
      a_pt_in     = a_pt_ff;
      prod_l_in   = prod_l_ff;
      prod_r_in   = prod_r_ff;
      ecnt_in     = ecnt_ff;
      e_in        = e_ff;
      out_pt_in   = out_pt_ff;
      out_last_in = out_last_ff;
      ps_we       = 1'b0;
      ps_waddr    = '0;
      ps_wdata    = '0;
      ps_raddr    = '0;
      st_we       = 1'b0;
      st_waddr    = '0;
      st_wdata    = '0;
      st_raddr    = '0;
      req.ready   = 1'b0;
      rsp.valid   = 1'b0;

      unique case (state_ff)
         cvxh_pkg::S_LOAD: begin
            req.ready = 1'b1;
            if (req_fire) begin
               if (store_full) begin
                  ovf_in = 1'b1;
               end else begin
                  ps_we    = 1'b1;
                  ps_waddr = cnt_ff[IW-1:0];
                  ps_wdata = {req.point_x, req.point_y};
                  cnt_in   = CW'(cnt_ff + CW'(1));
               end
               i_in = CW'(1);
            end
         end
         cvxh_pkg::S_SORT_NEXT: begin
            ps_raddr = i_ff[IW-1:0];
         end
         cvxh_pkg::S_SORT_KEY: begin
            t_in = ps_rdata_ff;
            j_in = i_ff;
         end
         cvxh_pkg::S_SORT_RD: begin
            if (j_zero) begin
               ps_we    = 1'b1;
               ps_waddr = '0;
               ps_wdata = t_ff;
               i_in     = CW'(i_ff + CW'(1));
            end else begin
               ps_raddr = IW'(j_ff - CW'(1));
            end
         end
         cvxh_pkg::S_SORT_CMP: begin
            ps_we    = 1'b1;
            ps_waddr = j_ff[IW-1:0];
            if (shift_up) begin
               ps_wdata = ps_rdata_ff;
               j_in     = CW'(j_ff - CW'(1));
            end else begin
               ps_wdata = t_ff;
               i_in     = CW'(i_ff + CW'(1));
            end
         end
         cvxh_pkg::S_DD_INIT: begin
            ps_raddr = '0;
         end
         cvxh_pkg::S_DD_FIRST: begin
            prev_in = ps_rdata_ff;
            m_in    = CW'(1);
            i_in    = CW'(1);
         end
         cvxh_pkg::S_DD_NEXT: begin
            ps_raddr = i_ff[IW-1:0];
         end
         cvxh_pkg::S_DD_CMP: begin
            if (dd_keep) begin
               ps_we    = 1'b1;
               ps_waddr = m_ff[IW-1:0];
               ps_wdata = ps_rdata_ff;
               m_in     = CW'(m_ff + CW'(1));
               prev_in  = ps_rdata_ff;
            end
            i_in = CW'(i_ff + CW'(1));
         end
         cvxh_pkg::S_HULL_INIT: begin
            top_in   = '0;
            k_in     = '0;
            upper_in = 1'b0;
            floor_in = TW'(3);
         end
         cvxh_pkg::S_SINGLE: begin
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = '0;
            ecnt_in  = TW'(1);
            e_in     = '0;
         end
         cvxh_pkg::S_PUSH: begin
            ps_raddr = k_ff[IW-1:0];
         end
         cvxh_pkg::S_PUSH_WR: begin
            st_we     = 1'b1;
            st_waddr  = top_ff[SW-1:0];
            st_wdata  = k_ff[IW-1:0];
            p2_idx_in = p1_idx_ff;
            p2_pt_in  = p1_pt_ff;
            p1_idx_in = k_ff[IW-1:0];
            p1_pt_in  = ps_rdata_ff;
            top_in    = TW'(top_ff + TW'(1));
         end
         cvxh_pkg::S_CHECK: begin
            st_raddr = SW'(top_ff - TW'(3));
         end
         cvxh_pkg::S_CHK_A1: begin
            a_idx_in = st_rdata_ff;
            ps_raddr = st_rdata_ff;
         end
         cvxh_pkg::S_CHK_A2: begin
            a_pt_in   = ps_rdata_ff;
            prod_l_in = PW'(DW'(bx) - DW'(ax)) * PW'(DW'(cy) - DW'(by));
            prod_r_in = PW'(DW'(cx) - DW'(bx)) * PW'(DW'(by) - DW'(ay));
         end
         cvxh_pkg::S_CHK_CMP: begin
            // Not a clockwise turn: the middle entry leaves the stack.
            if (!clockwise) begin
               st_we     = 1'b1;
               st_waddr  = SW'(top_ff - TW'(2));
               st_wdata  = p1_idx_ff;
               top_in    = TW'(top_ff - TW'(1));
               p2_idx_in = a_idx_ff;
               p2_pt_in  = a_pt_ff;
            end
         end
         cvxh_pkg::S_ADV: begin
            if (!upper_ff) begin
               if (lower_end) begin
                  upper_in = 1'b1;
                  floor_in = TW'(top_ff + TW'(2));
                  k_in     = CW'(m_ff - CW'(2));
               end else begin
                  k_in = CW'(k_ff + CW'(1));
               end
            end else if (!upper_end) begin
               k_in = CW'(k_ff - CW'(1));
            end
         end
         cvxh_pkg::S_FINISH: begin
            ecnt_in = hull_len;
            e_in    = '0;
         end
         cvxh_pkg::S_EMIT_RD: begin
            st_raddr = e_ff[SW-1:0];
         end
         cvxh_pkg::S_EMIT_PT: begin
            ps_raddr = st_rdata_ff;
         end
         cvxh_pkg::S_EMIT_LD: begin
            out_pt_in   = ps_rdata_ff;
            out_last_in = (TW'(e_ff + TW'(1)) == ecnt_ff);
         end
         cvxh_pkg::S_EMIT_WAIT: begin
            rsp.valid = 1'b1;
            if (rsp_fire) begin
               e_in = TW'(e_ff + TW'(1));
               if (out_last_ff) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.hull_x      = $signed(out_pt_ff[PTW-1:COORD_BITS]);
   assign rsp.hull_y      = $signed(out_pt_ff[COORD_BITS-1:0]);
   assign rsp.last_vertex = out_last_ff;
   assign rsp.overflow    = ovf_ff;

   always_ff @(posedge clock) begin
      if (ps_we) pstore[ps_waddr] <= ps_wdata;
      ps_rdata_ff <= pstore[ps_raddr];
   end

   always_ff @(posedge clock) begin
      if (st_we) hstack[st_waddr] <= st_wdata;
      st_rdata_ff <= hstack[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cvxh_pkg::S_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         top_ff   <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      m_ff        <= m_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      prev_ff     <= prev_in;
      floor_ff    <= floor_in;
      upper_ff    <= upper_in;
      p1_idx_ff   <= p1_idx_in;
      p1_pt_ff    <= p1_pt_in;
      p2_idx_ff   <= p2_idx_in;
      p2_pt_ff    <= p2_pt_in;
      a_idx_ff    <= a_idx_in;
      a_pt_ff     <= a_pt_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      ecnt_ff     <= ecnt_in;
      e_ff        <= e_in;
      out_pt_ff   <= out_pt_in;
      out_last_ff <= out_last_in;
   end

   // The point count never passes the store size.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_POINTS))
      else $error("point count beyond store size");

   // Loading and output never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("input and output open together");

   // After the final vertex the set state is cleared.
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp.last_vertex) |=> (cnt_ff == '0 && !ovf_ff && req.ready))
      else $error("set not cleared after final vertex");

   // The stack stays within its memory.
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TW'(SD))
      else $error("hull stack beyond its depth");

endmodule

// ----- tb/sv/cvxh_scoreboard.sv -----
package cvxh_test_pkg;

   localparam int MaxPts = 32;
   localparam int CBits  = 24;

   typedef struct packed {
      logic signed [CBits-1:0] x;
      logic signed [CBits-1:0] y;
      logic                    last_vertex;
      logic                    overflow;
   } vertex_type;

   class hull_scoreboard;
      logic signed [CBits-1:0] px[MaxPts];
      logic signed [CBits-1:0] py[MaxPts];
      int unsigned count;
      bit          dropped;
      vertex_type  pending[$];
      int          errors;
      int          sets;
      int          vertices;

      function new();
         count = 0;
         dropped = 0;
         errors = 0;
         sets = 0;
         vertices = 0;
      endfunction

      // Strictly clockwise turn at b on the path a -> b -> c.
      function bit turns_right(int a, int b, int c);
         longint lhs;
         longint rhs;
         lhs = (longint'(px[b]) - px[a]) * (longint'(py[c]) - py[b]);
         rhs = (longint'(px[c]) - px[b]) * (longint'(py[b]) - py[a]);
         return lhs < rhs;
      endfunction

      function void push_idx(ref int stk[$], input int idx, input int floor_top);
         stk = {stk, idx};
         while (stk.size() >= floor_top && stk.size() >= 3 &&
               !turns_right(stk[stk.size()-3], stk[stk.size()-2], stk[stk.size()-1])) begin
            stk.delete(stk.size()-2);
         end
      endfunction

      function void note_point(logic signed [CBits-1:0] x, logic signed [CBits-1:0] y,
                               logic last_point);
         int m;
         int lower;
         int stk[$];
         logic signed [CBits-1:0] tx;
         logic signed [CBits-1:0] ty;
         vertex_type v;
         if (count < MaxPts) begin
            px[count] = x;
            py[count] = y;
            count++;
         end else begin
            dropped = 1;
         end
         if (!last_point) return;
         sets++;
         // Insertion sort by x, then y.
         for (int i = 1; i < count; i++) begin
            int j;
            tx = px[i];
            ty = py[i];
            j = i;
            while (j > 0 && (px[j-1] > tx || (px[j-1] == tx && py[j-1] > ty))) begin
               px[j] = px[j-1];
               py[j] = py[j-1];
               j--;
            end
            px[j] = tx;
            py[j] = ty;
         end
         m = 1;
         for (int i = 1; i < count; i++) begin
            if (px[m-1] != px[i] || py[m-1] != py[i]) begin
               px[m] = px[i];
               py[m] = py[i];
               m++;
            end
         end
         if (m == 1) begin
            v = '{px[0], py[0], 1'b1, dropped};
            pending = {pending, v};
         end else begin
            for (int i = 0; i < m; i++) push_idx(stk, i, 3);
            lower = stk.size();
            for (int i = m - 1; i > 0; i--) push_idx(stk, i - 1, lower + 2);
            stk.delete(stk.size() - 1);
            for (int i = 0; i < stk.size(); i++) begin
               v = '{px[stk[i]], py[stk[i]], i + 1 == stk.size(), dropped};
               pending = {pending, v};
            end
         end
         count = 0;
         dropped = 0;
      endfunction

      function void check_vertex(vertex_type got);
         vertex_type want;
         vertices++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected vertex, actual %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: vertex mismatch, expected %p, actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

endpackage

// ----- tb/sv/convex_hull_monotone_chain_test.sv -----
module convex_hull_monotone_chain_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CBits = cvxh_test_pkg::CBits;
   localparam int MaxPts = cvxh_test_pkg::MaxPts;
   localparam int WatchLimit = 200000;

   logic clock = 0;
   logic reset = 1;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   cvxh_req_if #(.COORD_BITS(CBits)) req ();
   cvxh_rsp_if #(.COORD_BITS(CBits)) rsp ();

   convex_hull_monotone_chain #(.MAX_POINTS(MaxPts), .COORD_BITS(CBits)) DUT (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   cvxh_test_pkg::hull_scoreboard board = new();
   int points_sent = 0;
   int idle_cycles = 0;

   // Every transfer on either channel feeds the scoreboard; the watchdog
   // counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            board.note_point(req.point_x, req.point_y, req.last_point);
            points_sent++;
         end
         if (rsp.valid && rsp.ready) begin
            board.check_vertex('{rsp.hull_x, rsp.hull_y, rsp.last_vertex, rsp.overflow});
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("convex_hull_monotone_chain_test failed");
            $finish;
         end
      end
   end

   // The receiver alternates between stretches of steady acceptance and
   // stretches of random stalls so that back pressure hits every vertex slot.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 0;
      end else if (($time / 4000) % 3 == 0) begin
         rsp.ready <= 1;
      end else begin
         rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Offer one point and hold it until the block takes it. A nonzero gap
   // drops valid and waits out the gap first; with no gap the next point
   // follows straight on, so valid stays high across a burst.
   task automatic send_point(logic signed [CBits-1:0] x, logic signed [CBits-1:0] y,
                             logic last_point, int gap);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1;
      req.point_x <= x;
      req.point_y <= y;
      req.last_point <= last_point;
      do @(posedge clock); while (!req.ready);
   endtask

   function automatic logic signed [CBits-1:0] rand_coord(int spread);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return {1'b0, {(CBits-1){1'b1}}};
      if (pick == 1) return {1'b1, {(CBits-1){1'b0}}};
      if (pick < 4) return CBits'($urandom);
      return CBits'($signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // A full set of points with random spacing; the burst shape comes from
   // the gap chosen per point.
   task automatic send_set(int n, int spread);
      int burst;
      burst = 0;
      for (int i = 0; i < n; i++) begin
         int gap;
         if (burst == 0) begin
            burst = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
         end else begin
            gap = 0;
         end
         burst--;
         send_point(rand_coord(spread), rand_coord(spread), i == n - 1, gap);
      end
   endtask

   // Release the input, then wait until every expected vertex has arrived.
   task automatic wait_drained();
      req.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      req.valid <= 0;
      req.point_x <= '0;
      req.point_y <= '0;
      req.last_point <= 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Single point, extreme values, closes its own set.
      send_point({1'b0, {(CBits-1){1'b1}}}, {1'b1, {(CBits-1){1'b0}}}, 1, 0);
      // Duplicates collapse to one distinct point.
      send_point(24'sd5, -24'sd7, 0, 0);
      send_point(24'sd5, -24'sd7, 0, 0);
      send_point(24'sd5, -24'sd7, 1, 0);
      // All collinear: only the two end points remain.
      send_point(24'sd0, 24'sd0, 0, 0);
      send_point(24'sd256, 24'sd256, 0, 1);
      send_point(24'sd512, 24'sd512, 0, 0);
      send_point(-24'sd256, -24'sd256, 1, 2);
      // Square with an interior point and the full coordinate range.
      send_point({1'b1, {(CBits-1){1'b0}}}, {1'b1, {(CBits-1){1'b0}}}, 0, 0);
      send_point({1'b0, {(CBits-1){1'b1}}}, {1'b1, {(CBits-1){1'b0}}}, 0, 0);
      send_point({1'b0, {(CBits-1){1'b1}}}, {1'b0, {(CBits-1){1'b1}}}, 0, 0);
      send_point({1'b1, {(CBits-1){1'b0}}}, {1'b0, {(CBits-1){1'b1}}}, 0, 0);
      send_point(24'sd0, 24'sd0, 1, 0);
      wait_drained();

      // Overflow: more points than the store holds, the closing one dropped.
      send_set(MaxPts + 3, 1000);
      wait_drained();

      // Random sets, mostly small with tight clustering so collinear and
      // repeated points are common, a few at full store size.
      while (points_sent < 250) begin
         int n;
         n = ($urandom_range(0, 7) == 0) ? MaxPts : $urandom_range(1, 10);
         send_set(n, ($urandom_range(0, 1) == 0) ? 4 : 100000);
      end

      wait_drained();
      repeat (200) @(posedge clock);

      $display("Sent %0d points in %0d sets and checked %0d hull vertices.",
               points_sent, board.sets, board.vertices);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("convex_hull_monotone_chain_test passed");
      end else begin
         $display("convex_hull_monotone_chain_test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/cvxh_pkg.sv
rtl/cvxh_if.sv
rtl/convex_hull_monotone_chain.sv
tb/sv/cvxh_scoreboard.sv
tb/sv/convex_hull_monotone_chain_test.sv
